>>> sv/pmrt_pkg.sv
// Package for the pattern match run tracker: shared constants, register
// index codes, the front-to-back item type and small helper functions.
// No dependencies.
package pmrt_pkg;

   // Default sizing
   localparam int              PATTERN_MAX = 32;
   localparam longint unsigned TEXT_MAX    = 64'd16777216;

   // Pattern register file
   localparam int PAT_BYTES      = 32;
   localparam int PAT_BYTE_IDX_W = $clog2(PAT_BYTES);
   localparam int BYTES_PER_REG  = 8;
   localparam int LEN_W          = 6;

   // Configuration port
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES_3 = 3'd4;

   // Result field widths
   localparam int COUNT_W     = 25;
   localparam int OUT_SHIFT_W = 24;
   localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

   // Shift as carried between front and back (wide enough for the default TEXT_MAX)
   localparam int ITEM_SHIFT_W = 32;

   // Decoupling queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified text byte, front to back
   typedef struct packed {
      logic                    found;
      logic [ITEM_SHIFT_W-1:0] shift;
      logic [LEN_W-1:0]        len;
      logic                    last;
      logic                    overflow;
   } item_type;

   // Saturating increment of a count
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v == COUNT_SAT) ? COUNT_SAT : v + COUNT_W'(1);
      return r;
   endfunction

endpackage

>>> sv/pmrt_front.sv
// Front end of the pattern match run tracker: pattern registers, byte window,
// position counter and the parallel window compare. Depends on pmrt_pkg.
module pmrt_front #(
   parameter int              PATTERN_MAX = pmrt_pkg::PATTERN_MAX,
   parameter longint unsigned TEXT_MAX    = pmrt_pkg::TEXT_MAX
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [pmrt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pmrt_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 accept,
   input  logic [7:0]                           text_byte,
   input  logic                                 last_byte,
   output pmrt_pkg::item_type                   item
);

   localparam int WIN   = (PATTERN_MAX < pmrt_pkg::PAT_BYTES) ? PATTERN_MAX
                                                              : pmrt_pkg::PAT_BYTES;
   localparam int POS_W = $clog2(TEXT_MAX + 64'd1);
   localparam int LEN_W = pmrt_pkg::LEN_W;

   logic [LEN_W-1:0]                 len_ff, len_in;
   logic [pmrt_pkg::PAT_BYTES-1:0][7:0] pat_ff, pat_in;
   logic [WIN-1:0][7:0]              wnd_ff, wnd_in, wnd_next;
   logic [POS_W-1:0]                 pos_ff, pos_in;
   logic                             ovf_ff, ovf_in;

   logic [LEN_W-1:0]                 eff_len;
   logic [WIN-1:0]                   hit;
   logic                             pos_ok;
   logic [POS_W:0]                   pos_plus;
   logic [POS_W:0]                   shift_full;
   logic                             found;

   // Decode configuration writes
   always_comb begin
      len_in = len_ff;
      pat_in = pat_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            pmrt_pkg::CSR_PATTERN_LENGTH: begin
               len_in = csr_data[LEN_W-1:0];
            end
            pmrt_pkg::CSR_PATTERN_BYTES_0: begin
               pat_in[7:0] = csr_data;
            end
            pmrt_pkg::CSR_PATTERN_BYTES_1: begin
               pat_in[15:8] = csr_data;
            end
            pmrt_pkg::CSR_PATTERN_BYTES_2: begin
               pat_in[23:16] = csr_data;
            end
            pmrt_pkg::CSR_PATTERN_BYTES_3: begin
               pat_in[31:24] = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp the configured length to 1..WIN
   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > LEN_W'(WIN)) begin
         eff_len = LEN_W'(WIN);
      end else begin
         eff_len = len_ff;
      end
   end

   // Window after this beat: newest byte at slot 0
   always_comb begin
      wnd_next[0] = text_byte;
      for (int k = 1; k < WIN; k++) begin
         wnd_next[k] = wnd_ff[k-1];
      end
   end

   // Compare each window slot with the pattern byte that lines up with it
   always_comb begin
      logic [LEN_W-1:0] pidx;
      for (int i = 0; i < WIN; i++) begin
         pidx   = eff_len - LEN_W'(1) - LEN_W'(i);
         hit[i] = (LEN_W'(i) >= eff_len) ||
                  (wnd_next[i] == pat_ff[pidx[pmrt_pkg::PAT_BYTE_IDX_W-1:0]]);
      end
   end

   // Classify the beat
   assign pos_ok     = (pos_ff < POS_W'(TEXT_MAX));
   assign pos_plus   = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign found      = pos_ok && (pos_plus >= (POS_W+1)'(eff_len)) && (&hit);
   assign shift_full = found ? (pos_plus - (POS_W+1)'(eff_len)) : '0;

   always_comb begin
      item.found    = found;
      item.shift    = pmrt_pkg::ITEM_SHIFT_W'(shift_full);
      item.len      = eff_len;
      item.last     = last_byte;
      item.overflow = ovf_ff || !pos_ok;
   end

   // Advance window and position; drop all text state after the last beat
   always_comb begin
      wnd_in = wnd_ff;
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (last_byte) begin
            wnd_in = '0;
            pos_in = '0;
            ovf_in = 1'b0;
         end else begin
            wnd_in = wnd_next;
            if (pos_ok) begin
               pos_in = pos_plus[POS_W-1:0];
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
         pat_ff <= '0;
         wnd_ff <= '0;
         pos_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         pat_ff <= pat_in;
         wnd_ff <= wnd_in;
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

>>> sv/pmrt_queue.sv
// Short queue of classified items between front and back end.
// Depends on pmrt_pkg.
module pmrt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  pmrt_pkg::item_type wr_item,
   output logic               full,
   input  logic               rd_en,
   output pmrt_pkg::item_type rd_item,
   output logic               empty
);

   localparam int PTR_W = pmrt_pkg::QUEUE_PTR_W;
   localparam int CNT_W = pmrt_pkg::QUEUE_CNT_W;

   pmrt_pkg::item_type        mem_ff [pmrt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   assign full    = (cnt_ff == CNT_W'(pmrt_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_item = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(wr_en) - CNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

>>> sv/pmrt_back.sv
// Back end of the pattern match run tracker: match count, run tracking and
// the registered result stage. Depends on pmrt_pkg.
module pmrt_back #(
   parameter longint unsigned TEXT_MAX = pmrt_pkg::TEXT_MAX
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  pmrt_pkg::item_type                 q_item,
   output logic                               q_pop,
   input  logic                               pop,
   output logic                               empty,
   output logic                               rsp_match_found,
   output logic [pmrt_pkg::OUT_SHIFT_W-1:0]   rsp_match_shift,
   output logic                               rsp_is_last,
   output logic [pmrt_pkg::COUNT_W-1:0]       rsp_match_count,
   output logic [pmrt_pkg::COUNT_W-1:0]       rsp_best_run_length,
   output logic signed [pmrt_pkg::COUNT_W-1:0] rsp_best_run_start,
   output logic                               rsp_position_overflow
);

   localparam int SHIFT_W = $clog2(TEXT_MAX);
   localparam int CW      = pmrt_pkg::COUNT_W;
   localparam int OSW     = pmrt_pkg::OUT_SHIFT_W;

   logic [SHIFT_W-1:0] prev_ff, prev_in;
   logic               any_ff, any_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      cur_len_ff, cur_len_in;
   logic [SHIFT_W-1:0] cur_start_ff, cur_start_in;
   logic [CW-1:0]      long_len_ff, long_len_in;
   logic [CW-1:0]      long_start_ff, long_start_in;

   logic               out_valid_ff, out_valid_in;
   logic               out_found_ff;
   logic [OSW-1:0]     out_shift_ff;
   logic               out_last_ff;
   logic [CW-1:0]      out_count_ff;
   logic [CW-1:0]      out_len_ff;
   logic [CW-1:0]      out_start_ff;
   logic               out_ovf_ff;

   logic [SHIFT_W-1:0] shift;
   logic [SHIFT_W:0]   gap;
   logic               in_run;
   logic [CW-1:0]      cur_len_inc;
   logic [63:0]        shift64;
   logic [63:0]        cur_start64;

   // Take an item when the result stage is free or drains this cycle
   assign q_pop = !q_empty && (!out_valid_ff || pop);

   assign shift       = q_item.shift[SHIFT_W-1:0];
   assign gap         = {1'b0, shift} - {1'b0, prev_ff};
   assign in_run      = any_ff && (gap == (SHIFT_W+1)'(q_item.len));
   assign cur_len_inc = pmrt_pkg::sat_inc(cur_len_ff);
   assign shift64     = 64'(shift);
   assign cur_start64 = 64'(cur_start_ff);

   // Update count and runs for a found occurrence
   always_comb begin
      prev_in       = prev_ff;
      any_in        = any_ff;
      count_in      = count_ff;
      cur_len_in    = cur_len_ff;
      cur_start_in  = cur_start_ff;
      long_len_in   = long_len_ff;
      long_start_in = long_start_ff;
      if (q_item.found) begin
         count_in = pmrt_pkg::sat_inc(count_ff);
         if (in_run) begin
            cur_len_in = cur_len_inc;
            if (cur_len_inc > long_len_ff) begin
               long_len_in   = cur_len_inc;
               long_start_in = cur_start64[CW-1:0];
            end
         end else begin
            cur_len_in   = CW'(1);
            cur_start_in = shift;
            if (long_len_ff == '0) begin
               long_len_in   = CW'(1);
               long_start_in = shift64[CW-1:0];
            end
         end
         prev_in = shift;
         any_in  = 1'b1;
      end
   end

   // Hold the run state; clear it after the last beat of a text
   always_ff @(posedge clock) begin
      if (reset || (q_pop && q_item.last)) begin
         prev_ff       <= '0;
         any_ff        <= 1'b0;
         count_ff      <= '0;
         cur_len_ff    <= '0;
         cur_start_ff  <= '0;
         long_len_ff   <= '0;
         long_start_ff <= '1;
      end else if (q_pop) begin
         prev_ff       <= prev_in;
         any_ff        <= any_in;
         count_ff      <= count_in;
         cur_len_ff    <= cur_len_in;
         cur_start_ff  <= cur_start_in;
         long_len_ff   <= long_len_in;
         long_start_ff <= long_start_in;
      end
   end

   // Result stage valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the result payload; summary fields only on the last beat
   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_found_ff <= q_item.found;
         out_shift_ff <= shift64[OSW-1:0];
         out_last_ff  <= q_item.last;
         out_count_ff <= q_item.last ? count_in      : '0;
         out_len_ff   <= q_item.last ? long_len_in   : '0;
         out_start_ff <= q_item.last ? long_start_in : '0;
         out_ovf_ff   <= q_item.last && q_item.overflow;
      end
   end

   assign empty                 = !out_valid_ff;
   assign rsp_match_found       = out_found_ff;
   assign rsp_match_shift       = out_shift_ff;
   assign rsp_is_last           = out_last_ff;
   assign rsp_match_count       = out_count_ff;
   assign rsp_best_run_length   = out_len_ff;
   assign rsp_best_run_start    = out_start_ff;
   assign rsp_position_overflow = out_ovf_ff;

endmodule

>>> sv/pattern_match_run_tracker.sv
// Top level of the pattern match run tracker: front end, decoupling queue and
// back end. Depends on pmrt_pkg, pmrt_front, pmrt_queue and pmrt_back.
//
//   channel   handshake          beat
//   -------   ----------------   ---------------------------------------------
//   request   push / full        req_text_byte, req_last_byte
//   response  pop / empty        rsp_match_found .. rsp_position_overflow
//   csr       csr_write_en       csr_index, csr_data (no wait, no read-back)
//
// One text byte per cycle sustained while full stays low. A byte is compared
// against the full window in the cycle it is taken; its result reaches the
// response side through the queue entry, then the result register.
// Reset is synchronous; there is no clearing pass.
// A stalled response fills the two-entry queue, after which full rises.
module pattern_match_run_tracker #(
   parameter int              PATTERN_MAX = pmrt_pkg::PATTERN_MAX,
   parameter longint unsigned TEXT_MAX    = pmrt_pkg::TEXT_MAX
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [pmrt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pmrt_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                push,
   output logic                                full,
   input  logic [7:0]                          req_text_byte,
   input  logic                                req_last_byte,
   output logic                                empty,
   input  logic                                pop,
   output logic                                rsp_match_found,
   output logic [pmrt_pkg::OUT_SHIFT_W-1:0]    rsp_match_shift,
   output logic                                rsp_is_last,
   output logic [pmrt_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic [pmrt_pkg::COUNT_W-1:0]        rsp_best_run_length,
   output logic signed [pmrt_pkg::COUNT_W-1:0] rsp_best_run_start,
   output logic                                rsp_position_overflow
);

   logic               accept;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;
   pmrt_pkg::item_type front_item;
   pmrt_pkg::item_type q_item;

   assign full   = q_full;
   assign accept = push && !q_full;

   // Classify incoming bytes
   pmrt_front #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .accept       (accept),
      .text_byte    (req_text_byte),
      .last_byte    (req_last_byte),
      .item         (front_item)
   );

   // Decouple front and back
   pmrt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_item (front_item),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_item (q_item),
      .empty   (q_empty)
   );

   // Track counts and runs, register the response
   pmrt_back #(
      .TEXT_MAX (TEXT_MAX)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_empty               (q_empty),
      .q_item                (q_item),
      .q_pop                 (q_pop),
      .pop                   (pop),
      .empty                 (empty),
      .rsp_match_found       (rsp_match_found),
      .rsp_match_shift       (rsp_match_shift),
      .rsp_is_last           (rsp_is_last),
      .rsp_match_count       (rsp_match_count),
      .rsp_best_run_length   (rsp_best_run_length),
      .rsp_best_run_start    (rsp_best_run_start),
      .rsp_position_overflow (rsp_position_overflow)
   );

endmodule
